/* src/length_table_checksum_deframer_macros.svh */
// Assertion shorthands used by the deframer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef LENGTH_TABLE_CHECKSUM_DEFRAMER_MACROS_SVH
`define LENGTH_TABLE_CHECKSUM_DEFRAMER_MACROS_SVH

// Condition holds at every edge outside reset.
`define LTCD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LTCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LTCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ltcd_pkg.sv */
package ltcd_pkg;

  localparam int BUFFER_DEPTH      = 32;
  localparam int MAX_DATA          = 16;
  localparam int MAX_FUNCTION_CODE = 7;
  localparam int FRAME_OVERHEAD    = 4;
  localparam int DATA_OFFSET       = 3;

  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 8;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W  = $clog2(MAX_DATA + FRAME_OVERHEAD + 1);
  localparam int OFS_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;
  localparam int CMP_W  = ((FILL_W > BYTE_W) ? FILL_W : BYTE_W) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE  = CFG_INDEX_W'(1);

  typedef struct packed {
    logic [CODE_W-1:0] function_code;
    logic [BYTE_W-1:0] data_byte;
    logic              data_present;
    logic              last;
  } res_t;

endpackage

/* src/length_table_checksum_deframer.sv */
// Channel  Ports (valid/ready)               Payload
// cfg      cfg_valid / cfg_ready             cfg_index (0 header, 1 length table), cfg_data
// in       in_valid / in_ready               in_rx_byte
// out      out_valid / out_ready             out_function_code, out_data_byte,
//                                            out_data_present, out_last
//
// One byte is taken per scan; the scanner reads the ring through a registered port: it
// reads the header, checks it, drops a byte on each mismatch, checks code and length,
// sums the data and compares the checksum, then emits one result per data byte (a single one for an empty frame).
// Up to four results wait in a queue ahead of the output register, so the scanner stalls
// only when that queue is full; the input waits until the scan ends.
// Reset (rst_n low, synchronous) empties the buffer and clears both config registers.
module length_table_checksum_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ltcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ltcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ltcd_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ltcd_pkg::CODE_W-1:0]      out_function_code,
  output logic [ltcd_pkg::BYTE_W-1:0]      out_data_byte,
  output logic                             out_data_present,
  output logic                             out_last
);
  import ltcd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  res_t q_data, q_head;

  assign cfg_ready = 1'b1;

  ltcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_push     (q_push),
    .q_data     (q_data),
    .q_full     (q_full)
  );

  ltcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ltcd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_function_code (out_function_code),
    .out_data_byte     (out_data_byte),
    .out_data_present  (out_data_present),
    .out_last          (out_last)
  );

endmodule

/* src/ltcd_front.sv */
`include "length_table_checksum_deframer_macros.svh"

module ltcd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [ltcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ltcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ltcd_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                             q_push,
  output ltcd_pkg::res_t                   q_data,
  input  logic                             q_full
);
  import ltcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_H_RD  = 3'd1;
  localparam logic [2:0] S_H_CHK = 3'd2;
  localparam logic [2:0] S_CODE  = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
  localparam logic [OFS_W-1:0]  OFS_ONE   = OFS_W'(1);
  localparam logic [OFS_W-1:0]  OFS_TWO   = OFS_W'(2);
  localparam logic [OFS_W-1:0]  OFS_DATA  = OFS_W'(DATA_OFFSET);
  localparam logic [OFS_W-1:0]  OFS_OVH   = OFS_W'(FRAME_OVERHEAD);
  localparam logic [OFS_W:0]    DEPTH_EXT = (OFS_W + 1)'(BUFFER_DEPTH);
  localparam logic [BYTE_W-1:0] MAX_CODE_B = BYTE_W'(MAX_FUNCTION_CODE);
  localparam logic [BYTE_W-1:0] MAX_DATA_B = BYTE_W'(MAX_DATA);
  localparam logic [CMP_W-1:0]  OVH_CMP    = CMP_W'(FRAME_OVERHEAD);

  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [OFS_W-1:0] ofs);
    logic [OFS_W:0] s;
    s = {{(OFS_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, ofs};
    if (s >= DEPTH_EXT) s = s - DEPTH_EXT;
    return s[ADDR_W-1:0];
  endfunction

  logic [BYTE_W-1:0]     mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0]     rdata_r;
  logic [ADDR_W-1:0]     raddr;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;

  logic [2:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     rp_r, rp_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic [BYTE_W-1:0]     len_r, len_nxt;
  logic [BYTE_W-1:0]     sum_r, sum_nxt;
  logic [OFS_W-1:0]      idx_r, idx_nxt;
  logic [BYTE_W-1:0]     header_r;
  logic [CFG_DATA_W-1:0] table_r;

  logic [BYTE_W-1:0]     expect_len;
  logic [OFS_W-1:0]      len_ofs;
  logic [OFS_W-1:0]      frame_ofs;
  logic                  short_frame;
  logic                  last_data;

  assign in_ready    = (state_r == S_IDLE);
  assign expect_len  = table_r[BYTE_W * code_r +: BYTE_W];
  assign len_ofs     = OFS_W'(len_r);
  assign frame_ofs   = len_ofs + OFS_OVH;
  assign short_frame = CMP_W'(fill_r) < (CMP_W'(rdata_r) + OVH_CMP);
  assign last_data   = (idx_r == len_ofs + OFS_TWO);

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    fill_nxt  = fill_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    raddr     = rp_r;
    we        = 1'b0;
    waddr     = ring_add(rp_r, OFS_W'(fill_r));
    q_push    = 1'b0;
    q_data    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          we = 1'b1;
          if (fill_r == FILL_FULL) begin
            // overwrite the oldest byte
            waddr  = rp_r;
            rp_nxt = ring_add(rp_r, OFS_ONE);
          end else begin
            fill_nxt = fill_r + FILL_ONE;
          end
          state_nxt = S_H_RD;
        end
      end
      S_H_RD: begin
        raddr     = rp_r;
        state_nxt = (fill_r == '0) ? S_IDLE : S_H_CHK;
      end
      S_H_CHK: begin
        if (rdata_r != header_r) begin
          rp_nxt    = ring_add(rp_r, OFS_ONE);
          fill_nxt  = fill_r - FILL_ONE;
          raddr     = ring_add(rp_r, OFS_ONE);
          state_nxt = (fill_r == FILL_ONE) ? S_IDLE : S_H_CHK;
        end else if (CMP_W'(fill_r) < OVH_CMP) begin
          state_nxt = S_IDLE;
        end else begin
          raddr     = ring_add(rp_r, OFS_ONE);
          state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        if (rdata_r > MAX_CODE_B) begin
          rp_nxt    = ring_add(rp_r, OFS_ONE);
          fill_nxt  = fill_r - FILL_ONE;
          raddr     = ring_add(rp_r, OFS_ONE);
          state_nxt = S_H_CHK;
        end else begin
          code_nxt  = rdata_r[CODE_W-1:0];
          sum_nxt   = header_r + rdata_r;
          raddr     = ring_add(rp_r, OFS_TWO);
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (expect_len > MAX_DATA_B || rdata_r != expect_len) begin
          rp_nxt    = ring_add(rp_r, OFS_ONE);
          fill_nxt  = fill_r - FILL_ONE;
          raddr     = ring_add(rp_r, OFS_ONE);
          state_nxt = S_H_CHK;
        end else if (short_frame) begin
          // wait for the rest of the frame
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = rdata_r;
          sum_nxt   = sum_r + rdata_r;
          idx_nxt   = OFS_DATA;
          raddr     = ring_add(rp_r, OFS_DATA);
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (idx_r == len_ofs + OFS_DATA) begin
          if (sum_r != rdata_r) begin
            rp_nxt    = ring_add(rp_r, OFS_ONE);
            fill_nxt  = fill_r - FILL_ONE;
            raddr     = ring_add(rp_r, OFS_ONE);
            state_nxt = S_H_CHK;
          end else begin
            idx_nxt   = OFS_DATA;
            raddr     = ring_add(rp_r, OFS_DATA);
            state_nxt = S_EMIT;
          end
        end else begin
          sum_nxt = sum_r + rdata_r;
          idx_nxt = idx_r + OFS_ONE;
          raddr   = ring_add(rp_r, idx_r + OFS_ONE);
        end
      end
      S_EMIT: begin
        raddr = ring_add(rp_r, idx_r);
        if (!q_full) begin
          q_push               = 1'b1;
          q_data.function_code = code_r;
          if (len_r == '0) begin
            q_data.last = 1'b1;
          end else begin
            q_data.data_byte    = rdata_r;
            q_data.data_present = 1'b1;
            q_data.last         = last_data;
          end
          if (len_r == '0 || last_data) begin
            // consume the whole frame
            rp_nxt    = ring_add(rp_r, frame_ofs);
            fill_nxt  = fill_r - FILL_W'(frame_ofs);
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + OFS_ONE;
            raddr   = ring_add(rp_r, idx_r + OFS_ONE);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_rx_byte;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rp_r     <= '0;
      fill_r   <= '0;
      header_r <= '0;
      table_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
      if (cfg_valid && cfg_index == CFG_HEADER) begin
        header_r <= cfg_data[BYTE_W-1:0];
      end
      if (cfg_valid && cfg_index == CFG_TABLE) begin
        table_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    len_r  <= len_nxt;
    sum_r  <= sum_nxt;
    idx_r  <= idx_nxt;
  end

  `LTCD_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_FULL, "fill count above buffer depth")
  `LTCD_ASSERT_IMPL(a_push_room, q_push, !q_full, "result pushed into a full queue")
  `LTCD_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_r == S_H_RD, "scan did not start")
  `LTCD_ASSERT_NEXT(a_fill_grow, in_valid && in_ready && fill_r != FILL_FULL, fill_r == $past(fill_r) + FILL_ONE, "fill count did not advance")
  `LTCD_ASSERT_IMPL(a_emit_fits, state_r == S_EMIT, CMP_W'(fill_r) >= CMP_W'(len_r) + OVH_CMP, "emitting a frame not fully buffered")

endmodule

/* src/ltcd_queue.sv */
module ltcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ltcd_pkg::res_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ltcd_pkg::res_t head
);
  import ltcd_pkg::*;

  localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(QUEUE_DEPTH);
  localparam logic [Q_CNT_W-1:0] CNT_ONE  = Q_CNT_W'(1);
  localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [Q_PTR_W-1:0] PTR_ONE  = Q_PTR_W'(1);

  res_t               slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_ONE;
    if (pop && !push) count_nxt = count_r - CNT_ONE;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
      end
    end
  end

endmodule

/* src/ltcd_back.sv */
module ltcd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  ltcd_pkg::res_t              q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ltcd_pkg::CODE_W-1:0] out_function_code,
  output logic [ltcd_pkg::BYTE_W-1:0] out_data_byte,
  output logic                        out_data_present,
  output logic                        out_last
);
  import ltcd_pkg::*;

  logic out_valid_r;
  res_t out_r;

  // refill the output register whenever it is empty or being taken
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  assign out_valid         = out_valid_r;
  assign out_function_code = out_r.function_code;
  assign out_data_byte     = out_r.data_byte;
  assign out_data_present  = out_r.data_present;
  assign out_last          = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= q_head;
    end
  end

endmodule
